// ===== rtl/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_DATA = '1;
    localparam logic [VAL_W-1:0] PUT_DATA  = '0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Input stream s_*: tdata carries key (bits 31:0) and value (63:32), tuser the
// operation (0 get, 1 put). Result stream m_*: tdata carries data, tuser the hit
// flag. Every input transaction yields exactly one result transaction.
// Capacity is to be written on the cfg_* channel (always ready) while the block
// idles, unenforced by the block; zero acts as 1, values above the entry count saturate.
//
// In the accept state the key is compared against all entry keys in parallel
// and the value memory is read; the update state that follows writes the
// value memory, updates recency ranks and loads the result register. s_tready
// is high only in the accept state, so one item is in flight at a time; a
// result waiting in the output register does not block the next accept. If the
// result register is still full at the update cycle, the update holds there
// until m_tready frees it.
// Reset empties the store (all entries invalid, ranks zero), sets capacity to
// 16 and drops any pending result. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_unit (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0]   cfg_data,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // key [31:0], value [63:32]
    input  wire [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] s_tdata,
    // op [0]
    input  wire                         s_tuser,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // data [31:0]
    output logic [lkvc_pkg::VAL_W-1:0]  m_tdata,
    // hit [0]
    output logic                        m_tuser
);
    import lkvc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    state_t                 state_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [KEY_W-1:0]       key_reg [ENTRIES];
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [RANK_W-1:0]      rank_reg [ENTRIES];
    logic [RANK_W-1:0]      rank_next [ENTRIES];
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [VAL_W-1:0]       val_mem [ENTRIES];
    logic [VAL_W-1:0]       rd_data_reg;

    op_t                    op_reg;
    logic [KEY_W-1:0]       in_key_reg;
    logic [VAL_W-1:0]       in_val_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       idx_reg;

    logic                   m_tvalid_reg;
    logic [VAL_W-1:0]       m_tdata_reg;
    logic                   m_tuser_reg;

    logic [KEY_W-1:0]       s_key;
    logic [VAL_W-1:0]       s_val;
    logic [ENTRIES-1:0]     match;
    logic [IDX_W-1:0]       found_idx;
    logic                   accept;
    logic                   out_free;
    logic                   done;

    logic [OCC_W-1:0]       lim;
    logic                   evict_need;
    logic [ENTRIES-1:0]     victim_mask;
    logic [ENTRIES-1:0]     valid_after;
    logic [IDX_W-1:0]       slot_idx;
    logic [RANK_W-1:0]      hit_rank;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;

    assign s_key     = s_tdata[KEY_W-1:0];
    assign s_val     = s_tdata[KEY_W+VAL_W-1:KEY_W];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done      = (state_reg == S_UPD) && out_free;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // parallel key match
    always_comb begin
        found_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == s_key);
            if (match[i]) begin
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            lim = OCC_W'(1);
        end else if (32'(cap_reg) > ENTRIES) begin
            lim = OCC_W'(ENTRIES);
        end else begin
            lim = OCC_W'(cap_reg);
        end
    end

    // victim has the largest rank among valid entries: occupancy - 1
    always_comb begin
        evict_need = (occ_reg >= lim) && (occ_reg != '0);
        for (int i = 0; i < ENTRIES; i++) begin
            victim_mask[i] = evict_need && valid_reg[i]
                             && (rank_reg[i] == RANK_W'(occ_reg - OCC_W'(1)));
        end
        valid_after = valid_reg & ~victim_mask;
        slot_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_after[i]) begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank = rank_reg[idx_reg];

    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (done) begin
            if (hit_reg) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && (IDX_W'(i) != idx_reg) && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                rank_next[idx_reg] = '0;
                mem_we = (op_reg == OP_PUT);
            end else if (op_reg == OP_PUT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_after[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                rank_next[slot_idx]  = '0;
                valid_next           = valid_after;
                valid_next[slot_idx] = 1'b1;
                occ_next             = evict_need ? occ_reg : occ_reg + OCC_W'(1);
                mem_we               = 1'b1;
                mem_waddr            = slot_idx;
            end
        end
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            val_mem[mem_waddr] <= in_val_reg;
        end
        if (accept) begin
            rd_data_reg <= val_mem[found_idx];
        end
    end

    // entry keys: written at insertion, compared at fixed places
    always_ff @(posedge aclk) begin
        if (done && !hit_reg && (op_reg == OP_PUT)) begin
            key_reg[slot_idx] <= in_key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // control state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_UPD;
                    end
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
        if (accept) begin
            op_reg     <= op_t'(s_tuser);
            in_key_reg <= s_key;
            in_val_reg <= s_val;
            hit_reg    <= |match;
            idx_reg    <= found_idx;
        end
        if (done) begin
            m_tuser_reg <= hit_reg;
            if (op_reg == OP_PUT) begin
                m_tdata_reg <= PUT_DATA;
            end else if (hit_reg) begin
                m_tdata_reg <= rd_data_reg;
            end else begin
                m_tdata_reg <= MISS_DATA;
            end
        end
    end

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) == $countones(valid_reg))
        else $error("occupancy disagrees with valid entries");

    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) && hit_reg |-> valid_reg[idx_reg])
        else $error("hit points at an invalid entry");

    a_occ_max: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) <= ENTRIES)
        else $error("occupancy above entry count");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_tvalid_reg && (state_reg == S_IDLE))
        else $error("update did not load the result register");

endmodule

`default_nettype wire

// ===== tb/sv/lru_key_value_cache_unit_test.sv =====
// Self-checking testbench for the LRU key-value cache: gets and puts checked against an LRU predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_unit_test;
    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 300;

    class cache_scoreboard;
        typedef struct {
            logic             hit;
            logic [VAL_W-1:0] data;
        } reply_t;

        logic [KEY_W-1:0] key_mem [ENTRIES];
        logic [VAL_W-1:0] val_mem [ENTRIES];
        bit               live    [ENTRIES];
        int               rank    [ENTRIES];
        int               occupancy;
        logic [CAP_W-1:0] capacity;
        reply_t           pending_replies [$];
        int               fail_count;
        int               transactions;
        int               hits;
        int               evictions;
        int               cap_writes;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                live[i] = 1'b0;
                rank[i] = 0;
            end
            occupancy = 0;
            capacity  = CAP_RESET;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
            cap_writes++;
        endfunction

        function int limit_now();
            if (capacity == 0)
                return 1;
            if (capacity > ENTRIES)
                return ENTRIES;
            return capacity;
        endfunction

        function void lru_promote(int s);
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && i != s && rank[i] < rank[s])
                    rank[i]++;
            rank[s] = 0;
        endfunction

        function void lru_evict();
            int victim;
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && (victim < 0 || rank[i] > rank[victim]))
                    victim = i;
            if (victim >= 0) begin
                live[victim] = 1'b0;
                occupancy--;
                evictions++;
            end
        endfunction

        // Predict the reply of one request and update the cache image.
        function void note_request(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            int     found;
            reply_t r;
            found = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && key_mem[i] == key)
                    found = i;
            r.hit = (found >= 0);
            transactions++;
            if (r.hit)
                hits++;
            if (op == OP_GET) begin
                if (found >= 0) begin
                    r.data = val_mem[found];
                    lru_promote(found);
                end else begin
                    r.data = MISS_DATA;
                end
            end else begin
                r.data = PUT_DATA;
                if (found >= 0) begin
                    val_mem[found] = value;
                    lru_promote(found);
                end else begin
                    if (occupancy >= limit_now())
                        lru_evict();
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!live[i]) begin
                            for (int j = 0; j < ENTRIES; j++)
                                if (live[j])
                                    rank[j]++;
                            live[i]    = 1'b1;
                            key_mem[i] = key;
                            val_mem[i] = value;
                            rank[i]    = 0;
                            occupancy++;
                            break;
                        end
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        task report(string msg);
            fail_count++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_response(logic hit, logic [VAL_W-1:0] data);
            reply_t r;
            if (pending_replies.size() == 0) begin
                report($sformatf("unexpected result hit=%0b data=%h", hit, data));
            end else begin
                r = pending_replies.pop_front();
                if (hit !== r.hit)
                    report($sformatf("hit %0b, expected %0b", hit, r.hit));
                if (data !== r.data)
                    report($sformatf("data %h, expected %h", data, r.data));
            end
        endtask

        task flush_leftovers();
            while (pending_replies.size() != 0) begin
                void'(pending_replies.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [KEY_W+VAL_W-1:0] s_tdata   = '0;  // key [31:0], value [63:32]
    logic                   s_tuser   = 1'b0; // op [0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [VAL_W-1:0]       m_tdata;         // data [31:0]
    logic                   m_tuser;         // hit [0]

    cache_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_armed     = 1'b0;
    int hold_cycles    = 0;
    int cycle_count    = 0;

    lru_key_value_cache_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(op_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[KEY_W+VAL_W-1:KEY_W]);
            if (cfg_valid && cfg_ready)
                sb.set_capacity(cfg_data);
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_armed && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input op_t op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                    input int idle_mode, input bit with_hold);
        logic [KEY_W-1:0] key_pool [$];
        int               depth;
        int               roll;
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        write_capacity(cap);
        case (idle_mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default: begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
        endcase
        depth = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
        depth += 4;
        for (int i = 0; i < depth; i++)
            key_pool.push_back($urandom);
        for (int i = 0; i < n_items; i++) begin
            // long output hold-off while items keep coming
            if (with_hold && i == 10)
                hold_armed = 1'b1;
            op   = op_t'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 80)
                key = key_pool[$urandom_range(depth - 1)];
            else if (roll < 90)
                key = $urandom;
            else
                key = pick_extreme();
            value = ($urandom_range(9) == 0) ? pick_extreme() : $urandom;
            send_item(op, key, value);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps [8];
        phase_caps = '{5'd1, 5'd2, 5'd5, 5'd8, 5'd17, 5'd31, 5'd16, 5'd4};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // capacity zero acts as one entry
        write_capacity(5'd0);
        send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h0000_0005, 32'hFFFF_FFFF);

        // three entries: update, LRU order, stored value equal to miss data
        write_capacity(5'd3);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_item(OP_PUT, 32'h0000_0007, 32'h0000_0007);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_PUT, 32'h0000_0008, 32'h8000_0000);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        for (int p = 0; p < 8; p++) begin
            run_random_phase(phase_caps[p], 153, p % 4, p == 4);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        sb.flush_leftovers();

        $display("Checked %0d transactions: %0d hits, %0d evictions, %0d capacity writes",
                 sb.transactions, sb.hits, sb.evictions, sb.cap_writes);
        $display("Capacities from zero to 31 under mixed idling and a %0d-cycle output hold",
                 HOLD_LEN);
        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache_unit.sv
tb/sv/lru_key_value_cache_unit_test.sv
